FILE: rtl/lr_pkg.sv
// Shared types for the line rasterizer.
// Holds the command code enum; depends on nothing.
package lr_pkg;

    // Command carried by each input word.
    typedef enum logic {
        FUNC_START   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

endpackage

FILE: rtl/line_rasterizer.sv
// Bresenham line rasterizer, one pixel per input word.
// Depends on lr_pkg for the command codes.
//
// Usage:
//   Command channel (cmd_valid / cmd_stall): each word carries func and two
//   endpoints. func = start loads a new line from (x_a, y_a) to (x_b, y_b)
//   and yields its first pixel; func = advance yields the next pixel. A
//   start during a line drops the line in progress.
//   Pixel channel (pix_valid / pix_stall): one word for every command word,
//   with px, py, last (far endpoint reached) and valid_res (low when an
//   advance arrives with no line in progress; coordinates are then zero).
//   Path: an accepted command word passes the command register, then the
//   pixel register, whose word drives the pixel channel.
//   Throughput: one word per cycle unless pix_stall holds the pixel word. The
//   step is a single pass of subtract, compare and increment between the
//   command register and the pixel register, and the line state is written
//   back in the same cycle, so a following advance sees it at once.
//   Stall: while the pixel register holds an untaken word, the command
//   register holds its word and cmd_stall rises for as long as both are
//   full; nothing is dropped.
//   Reset: rst_n clears all control state; no line is in progress and both
//   registers are empty.
module line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic                         func,
    input  logic signed [COORD_BITS-1:0] x_a,
    input  logic signed [COORD_BITS-1:0] y_a,
    input  logic signed [COORD_BITS-1:0] x_b,
    input  logic signed [COORD_BITS-1:0] y_b,
    output logic                         pix_valid,
    input  logic                         pix_stall,
    output logic signed [COORD_BITS-1:0] px,
    output logic signed [COORD_BITS-1:0] py,
    output logic                         last,
    output logic                         valid_res
);

    localparam int C  = COORD_BITS;
    localparam int DW = COORD_BITS + 1;   // endpoint difference
    localparam int SW = COORD_BITS + 2;   // doubled span
    localparam int EW = COORD_BITS + 3;   // doubled error term, signed

    // Command register
    logic          cmd_full_reg, cmd_full_next;
    lr_pkg::func_t func_reg;
    logic [C-1:0]  x_a_reg, y_a_reg, x_b_reg, y_b_reg;

    // Line state
    logic          active_reg, active_next;
    logic          steep_reg, steep_next;
    logic [C-1:0]  major_reg, major_next;
    logic [C-1:0]  minor_reg, minor_next;
    logic [C-1:0]  end_reg, end_next;
    logic [EW-1:0] err_reg, err_next;
    logic [SW-1:0] tmaj_reg, tmaj_next;
    logic [SW-1:0] tmin_reg, tmin_next;
    logic          down_reg, down_next;

    // Pixel register
    logic          pix_valid_reg, pix_valid_next;
    logic [C-1:0]  px_reg, px_next;
    logic [C-1:0]  py_reg, py_next;
    logic          last_reg, last_next;
    logic          vres_reg, vres_next;

    // Handshake
    logic          out_free;
    logic          step_en;
    logic          cmd_take;

    // Start setup
    logic [DW-1:0] dx, dy, adx, ady;
    logic          st_steep;
    logic [C-1:0]  m1, n1, m2, n2;
    logic          st_swap;
    logic [C-1:0]  ma, na, mb, nb;
    logic [DW-1:0] mspan, nd, nabs;

    // Step
    logic          is_start;
    logic          emit;
    logic          cur_steep, cur_down;
    logic [C-1:0]  cur_major, cur_minor, cur_end;
    logic [EW-1:0] cur_err, err_sub;
    logic [SW-1:0] cur_tmaj, cur_tmin;
    logic          fin, minor_step;

    assign out_free  = !pix_valid_reg || !pix_stall;
    assign step_en   = cmd_full_reg && out_free;
    assign cmd_stall = cmd_full_reg && !out_free;
    assign cmd_take  = cmd_valid && !cmd_stall;

    assign pix_valid = pix_valid_reg;
    assign px        = px_reg;
    assign py        = py_reg;
    assign last      = last_reg;
    assign valid_res = vres_reg;

    // Setup of a new line: steepness, axis swap and endpoint ordering.
    always_comb
    begin
        dx  = {x_b_reg[C-1], x_b_reg} - {x_a_reg[C-1], x_a_reg};
        dy  = {y_b_reg[C-1], y_b_reg} - {y_a_reg[C-1], y_a_reg};
        adx = dx[DW-1] ? (~dx + DW'(1)) : dx;
        ady = dy[DW-1] ? (~dy + DW'(1)) : dy;
        // Steep only when strictly steeper than 45 degrees
        st_steep = ady > adx;

        m1 = st_steep ? y_a_reg : x_a_reg;
        n1 = st_steep ? x_a_reg : y_a_reg;
        m2 = st_steep ? y_b_reg : x_b_reg;
        n2 = st_steep ? x_b_reg : y_b_reg;

        // Order so the major coordinate increases
        st_swap = $signed(m1) > $signed(m2);
        ma = st_swap ? m2 : m1;
        na = st_swap ? n2 : n1;
        mb = st_swap ? m1 : m2;
        nb = st_swap ? n1 : n2;

        mspan = {mb[C-1], mb} - {ma[C-1], ma};
        nd    = {nb[C-1], nb} - {na[C-1], na};
        nabs  = nd[DW-1] ? (~nd + DW'(1)) : nd;
    end

    // One Bresenham step on either the freshly set-up line or the stored one.
    always_comb
    begin
        is_start = (func_reg == lr_pkg::FUNC_START);
        emit     = is_start || active_reg;

        if (is_start)
        begin
            cur_steep = st_steep;
            cur_major = ma;
            cur_minor = na;
            cur_end   = mb;
            cur_err   = {3'b000, mspan[C-1:0]};
            cur_tmaj  = {1'b0, mspan[C-1:0], 1'b0};
            cur_tmin  = {1'b0, nabs[C-1:0], 1'b0};
            cur_down  = !($signed(na) < $signed(nb));
        end
        else
        begin
            cur_steep = steep_reg;
            cur_major = major_reg;
            cur_minor = minor_reg;
            cur_end   = end_reg;
            cur_err   = err_reg;
            cur_tmaj  = tmaj_reg;
            cur_tmin  = tmin_reg;
            cur_down  = down_reg;
        end

        fin        = $signed(cur_major) >= $signed(cur_end);
        err_sub    = cur_err - {1'b0, cur_tmin};
        minor_step = err_sub[EW-1];

        // Hold the line state unless this step emits a pixel
        active_next = active_reg;
        steep_next  = steep_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        end_next    = end_reg;
        err_next    = err_reg;
        tmaj_next   = tmaj_reg;
        tmin_next   = tmin_reg;
        down_next   = down_reg;

        if (emit)
        begin
            steep_next = cur_steep;
            end_next   = cur_end;
            tmaj_next  = cur_tmaj;
            tmin_next  = cur_tmin;
            down_next  = cur_down;
            major_next = cur_major;
            minor_next = cur_minor;
            err_next   = cur_err;
            if (fin)
            begin
                active_next = 1'b0;
            end
            else
            begin
                active_next = 1'b1;
                major_next  = cur_major + C'(1);
                if (minor_step)
                begin
                    minor_next = cur_down ? (cur_minor - C'(1)) : (cur_minor + C'(1));
                    err_next   = err_sub + {1'b0, cur_tmaj};
                end
                else
                begin
                    err_next = err_sub;
                end
            end
        end

        if (emit)
        begin
            px_next   = cur_steep ? cur_minor : cur_major;
            py_next   = cur_steep ? cur_major : cur_minor;
            last_next = fin;
            vres_next = 1'b1;
        end
        else
        begin
            px_next   = '0;
            py_next   = '0;
            last_next = 1'b0;
            vres_next = 1'b0;
        end
    end

    // Occupancy of the two registers
    always_comb
    begin
        if (cmd_take)
            cmd_full_next = 1'b1;
        else if (step_en)
            cmd_full_next = 1'b0;
        else
            cmd_full_next = cmd_full_reg;

        if (step_en)
            pix_valid_next = 1'b1;
        else if (out_free)
            pix_valid_next = 1'b0;
        else
            pix_valid_next = pix_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_full_reg  <= 1'b0;
            pix_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            steep_reg     <= 1'b0;
            major_reg     <= '0;
            minor_reg     <= '0;
            end_reg       <= '0;
            err_reg       <= '0;
            tmaj_reg      <= '0;
            tmin_reg      <= '0;
            down_reg      <= 1'b0;
        end
        else
        begin
            cmd_full_reg  <= cmd_full_next;
            pix_valid_reg <= pix_valid_next;
            if (step_en)
            begin
                active_reg <= active_next;
                steep_reg  <= steep_next;
                major_reg  <= major_next;
                minor_reg  <= minor_next;
                end_reg    <= end_next;
                err_reg    <= err_next;
                tmaj_reg   <= tmaj_next;
                tmin_reg   <= tmin_next;
                down_reg   <= down_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            func_reg <= lr_pkg::func_t'(func);
            x_a_reg  <= x_a;
            y_a_reg  <= y_a;
            x_b_reg  <= x_b;
            y_b_reg  <= y_b;
        end
        if (step_en)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            last_reg <= last_next;
            vres_reg <= vres_next;
        end
    end

    // An empty result word carries zero coordinates and no last flag
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !valid_res) |-> (px == '0 && py == '0 && !last))
        else $error("empty pixel word carries data");

    // A pixel that is not the far endpoint keeps the line running
    a_keep_active: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && emit && !fin) |=> (active_reg && pix_valid && valid_res && !last))
        else $error("line dropped before its far endpoint");

    // The far endpoint ends the line
    a_end_line: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && emit && fin) |=> (!active_reg && last))
        else $error("line still active after its last pixel");

    // A full command register behind a stalled pixel word must stall input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_full_reg && pix_valid && pix_stall) |-> cmd_stall)
        else $error("command accepted while pipeline is blocked");

endmodule
